FILE: hw/rtl/ltsu_pkg.sv
// shared types, register codes and the luma helper for the tint shift unit
// no dependencies; used by every module of the block
`default_nettype none

package ltsu_pkg;

  // fixed point widths
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned LUMA_W   = 18;  // 299*255 + 587*255 + 114*255 = 255000
  localparam int unsigned QUO_W    = 16;  // weight fraction bits
  localparam int unsigned WEIGHT_W = QUO_W + 1;
  localparam int unsigned DELTA_W  = CHAN_W + 1;
  localparam int unsigned PROD_W   = DELTA_W + WEIGHT_W + 1;
  localparam int unsigned DIV_CELLS = QUO_W;

  // luma coefficients
  localparam logic [LUMA_W-1:0] LUMA_KR = LUMA_W'(299);
  localparam logic [LUMA_W-1:0] LUMA_KG = LUMA_W'(587);
  localparam logic [LUMA_W-1:0] LUMA_KB = LUMA_W'(114);

  // configuration port
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_BASE_R = 3'd0,
    REG_BASE_G = 3'd1,
    REG_BASE_B = 3'd2,
    REG_TINT_R = 3'd3,
    REG_TINT_G = 3'd4,
    REG_TINT_B = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [CHAN_W-1:0] pixel_r;
    logic [CHAN_W-1:0] pixel_g;
    logic [CHAN_W-1:0] pixel_b;
    logic [CHAN_W-1:0] pixel_a;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_r;
    logic [CHAN_W-1:0] out_g;
    logic [CHAN_W-1:0] out_b;
    logic [CHAN_W-1:0] out_a;
  } pix_out_t;

  typedef struct packed {
    logic [CHAN_W-1:0] base_r;
    logic [CHAN_W-1:0] base_g;
    logic [CHAN_W-1:0] base_b;
    logic [CHAN_W-1:0] tint_r;
    logic [CHAN_W-1:0] tint_g;
    logic [CHAN_W-1:0] tint_b;
  } cfg_t;

  // values derived from the registers, held next to them
  typedef struct packed {
    logic [LUMA_W-1:0]        base_luma;
    logic signed [DELTA_W-1:0] delta_r;
    logic signed [DELTA_W-1:0] delta_g;
    logic signed [DELTA_W-1:0] delta_b;
    logic                     bypass;
  } coef_t;

  // item moving along the divider chain
  typedef struct packed {
    logic [LUMA_W-1:0] rem;
    logic [QUO_W-1:0]  quo;
    logic              sat;
    pix_in_t           pix;
  } div_item_t;

  function automatic logic [LUMA_W-1:0] luma_of(
    input logic [CHAN_W-1:0] r,
    input logic [CHAN_W-1:0] g,
    input logic [CHAN_W-1:0] b
  );
    logic [LUMA_W-1:0] yr;
    logic [LUMA_W-1:0] yg;
    logic [LUMA_W-1:0] yb;
    yr = LUMA_W'(r) * LUMA_KR;
    yg = LUMA_W'(g) * LUMA_KG;
    yb = LUMA_W'(b) * LUMA_KB;
    return yr + yg + yb;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ltsu_cfg.sv
// configuration registers with apb-style access and derived coefficients
// depends on ltsu_pkg
`default_nettype none

module ltsu_cfg
  import ltsu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready,
  output coef_t                      coef
);

  cfg_t  cfg_r, cfg_nxt;
  coef_t coef_r, coef_nxt;
  logic  wr_en;
  logic [2:0] idx;
  logic [CHAN_W-1:0] wbyte;

  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign idx        = cfg_paddr[4:2];
  assign wbyte      = cfg_pwdata[CHAN_W-1:0];
  assign cfg_pready = 1'b1;
  assign coef       = coef_r;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_BASE_R: cfg_nxt.base_r = wbyte;
        REG_BASE_G: cfg_nxt.base_g = wbyte;
        REG_BASE_B: cfg_nxt.base_b = wbyte;
        REG_TINT_R: cfg_nxt.tint_r = wbyte;
        REG_TINT_G: cfg_nxt.tint_g = wbyte;
        REG_TINT_B: cfg_nxt.tint_b = wbyte;
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_BASE_R: cfg_prdata = CFG_DATA_W'(cfg_r.base_r);
      REG_BASE_G: cfg_prdata = CFG_DATA_W'(cfg_r.base_g);
      REG_BASE_B: cfg_prdata = CFG_DATA_W'(cfg_r.base_b);
      REG_TINT_R: cfg_prdata = CFG_DATA_W'(cfg_r.tint_r);
      REG_TINT_G: cfg_prdata = CFG_DATA_W'(cfg_r.tint_g);
      REG_TINT_B: cfg_prdata = CFG_DATA_W'(cfg_r.tint_b);
      default:    cfg_prdata = '0;
    endcase
  end

  // coefficients follow the next register values, so they never lag a write
  always_comb begin
    coef_nxt.base_luma = luma_of(cfg_nxt.base_r, cfg_nxt.base_g, cfg_nxt.base_b);
    coef_nxt.delta_r   = $signed({1'b0, cfg_nxt.tint_r}) - $signed({1'b0, cfg_nxt.base_r});
    coef_nxt.delta_g   = $signed({1'b0, cfg_nxt.tint_g}) - $signed({1'b0, cfg_nxt.base_g});
    coef_nxt.delta_b   = $signed({1'b0, cfg_nxt.tint_b}) - $signed({1'b0, cfg_nxt.base_b});
    coef_nxt.bypass    = (cfg_nxt.base_r == '0) && (cfg_nxt.base_g == '0) &&
                         (cfg_nxt.base_b == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r  <= '0;
      coef_r <= '{base_luma: '0, delta_r: '0, delta_g: '0, delta_b: '0, bypass: 1'b1};
    end else begin
      cfg_r  <= cfg_nxt;
      coef_r <= coef_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ltsu_luma.sv
// front stages: pixel luma, then clamp test and divider seed
// depends on ltsu_pkg
`default_nettype none

module ltsu_luma
  import ltsu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  pix_in_t                in_data,
  input  wire logic [LUMA_W-1:0] base_luma,
  input  wire logic              ld_i,
  output logic                   ld_o,
  output logic                   v_o,
  output div_item_t              item_o
);

  logic              v0_r, v1_r;
  logic              ld0, ld1;
  logic [LUMA_W-1:0] luma_r;
  pix_in_t           pix_r;
  div_item_t         item_r, item_nxt;

  // stage loads when empty or when its item moves on
  assign ld1  = !v1_r || ld_i;
  assign ld0  = !v0_r || ld1;
  assign ld_o = ld0;
  assign v_o  = v1_r;
  assign item_o = item_r;

  // weight saturates at one when the pixel is at least as bright as the base
  always_comb begin
    item_nxt.sat = (luma_r >= base_luma);
    item_nxt.rem = item_nxt.sat ? '0 : luma_r;
    item_nxt.quo = '0;
    item_nxt.pix = pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      if (ld0) v0_r <= in_valid;
      if (ld1) v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld0) begin
      luma_r <= luma_of(in_data.pixel_r, in_data.pixel_g, in_data.pixel_b);
      pix_r  <= in_data;
    end
    if (ld1) item_r <= item_nxt;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ltsu_div_cell.sv
// one restoring division cell: produces one weight bit per item
// depends on ltsu_pkg
`default_nettype none

module ltsu_div_cell
  import ltsu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              v_i,
  input  div_item_t              item_i,
  input  wire logic [LUMA_W-1:0] base_luma,
  input  wire logic              ld_i,
  output logic                   ld_o,
  output logic                   v_o,
  output div_item_t              item_o
);

  logic        v_r;
  div_item_t   item_r, item_nxt;
  logic [LUMA_W:0] shl;
  logic [LUMA_W:0] diff;
  logic        qbit;

  assign ld_o   = !v_r || ld_i;
  assign v_o    = v_r;
  assign item_o = item_r;

  // remainder stays below the base, so the difference fits back in LUMA_W
  always_comb begin
    shl  = {item_i.rem, 1'b0};
    diff = shl - {1'b0, base_luma};
    qbit = (shl >= {1'b0, base_luma});
    item_nxt     = item_i;
    item_nxt.rem = qbit ? diff[LUMA_W-1:0] : shl[LUMA_W-1:0];
    item_nxt.quo = {item_i.quo[QUO_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ld_o) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_o) item_r <= item_nxt;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ltsu_blend.sv
// back stages: weighted delta products, then rounding, clamp and output register
// depends on ltsu_pkg
`default_nettype none

module ltsu_blend
  import ltsu_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  v_i,
  input  div_item_t  item_i,
  input  coef_t      coef,
  output logic       ld_o,
  output logic       out_valid,
  input  wire logic  out_stall,
  output pix_out_t   out_data
);

  logic                     vm_r, vo_r;
  logic                     ldm, ldo;
  logic [WEIGHT_W-1:0]      weight;
  logic signed [PROD_W-1:0] prod_r_r, prod_g_r, prod_b_r;
  pix_in_t                  pix_r;
  pix_out_t                 out_r, out_nxt;

  assign ldo       = !vo_r || !out_stall;
  assign ldm       = !vm_r || ldo;
  assign ld_o      = ldm;
  assign out_valid = vo_r;
  assign out_data  = out_r;

  assign weight = item_i.sat ? {1'b1, {QUO_W{1'b0}}} : {1'b0, item_i.quo};

  function automatic logic signed [PROD_W-1:0] mul_w(
    input logic signed [DELTA_W-1:0] d,
    input logic [WEIGHT_W-1:0]       w
  );
    logic signed [PROD_W-1:0] dx;
    logic signed [PROD_W-1:0] wx;
    dx = PROD_W'(d);
    wx = $signed(PROD_W'(w));
    return dx * wx;
  endfunction

  // p + delta*weight in q16, rounded half up, saturated to a byte
  function automatic logic [CHAN_W-1:0] round_clamp(
    input logic [CHAN_W-1:0]       p,
    input logic signed [PROD_W-1:0] prod
  );
    logic signed [PROD_W:0] num;
    num = $signed({{(PROD_W-CHAN_W-QUO_W+1){1'b0}}, p, {QUO_W{1'b0}}}) +
          (PROD_W+1)'(prod) + $signed((PROD_W+1)'(1 << (QUO_W-1)));
    if (num[PROD_W]) begin
      return '0;
    end else if (num[PROD_W-1:QUO_W+CHAN_W] != '0) begin
      return '1;
    end else begin
      return num[QUO_W+CHAN_W-1:QUO_W];
    end
  endfunction

  // output selection
  always_comb begin
    out_nxt.out_a = pix_r.pixel_a;
    if (coef.bypass) begin
      out_nxt.out_r = pix_r.pixel_r;
      out_nxt.out_g = pix_r.pixel_g;
      out_nxt.out_b = pix_r.pixel_b;
    end else begin
      out_nxt.out_r = round_clamp(pix_r.pixel_r, prod_r_r);
      out_nxt.out_g = round_clamp(pix_r.pixel_g, prod_g_r);
      out_nxt.out_b = round_clamp(pix_r.pixel_b, prod_b_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (ldm) vm_r <= v_i;
      if (ldo) vo_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ldm) begin
      prod_r_r <= mul_w(coef.delta_r, weight);
      prod_g_r <= mul_w(coef.delta_g, weight);
      prod_b_r <= mul_w(coef.delta_b, weight);
      pix_r    <= item_i.pix;
    end
    if (ldo) out_r <= out_nxt;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/luma_weighted_tint_shift_unit.sv
// luma weighted tint shift: one rgba8 pixel in, one shifted pixel out
// pixels enter on in_valid/in_stall with an in_data struct and leave on
// out_valid/out_stall with an out_data struct; an item moves when valid is
// high and stall is low. six 8-bit registers (base rgb, tint rgb) sit on the
// apb-style cfg_ port at byte addresses 0, 4, ... 20; write them while idle.
// an item passes through twenty stages from accept to out_valid: luma,
// divider seed, 16 division cells (one weight bit each), product, round/clamp
// output register.
// throughput is one item per cycle while out_stall is low; the divider is a
// chain of cells, each holding one item and passing it on when the next loads.
// when the receiver stalls, the output register holds its item and stages
// behind it keep filling empty slots, so up to 20 items are taken before
// in_stall rises. reset empties the pipeline and clears the six registers to 0;
// with the base colour at zero the pixel colour passes through unchanged.
// depends on ltsu_pkg, ltsu_cfg, ltsu_luma, ltsu_div_cell, ltsu_blend
`default_nettype none

module luma_weighted_tint_shift_unit
  import ltsu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  pix_in_t                    in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output pix_out_t                   out_data,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  coef_t     coef;
  logic      front_ld;
  logic      cell_v  [DIV_CELLS+1];
  div_item_t cell_it [DIV_CELLS+1];
  logic      cell_ld [DIV_CELLS+1];

  assign in_stall = !front_ld;

  // registers
  ltsu_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .coef        (coef)
  );

  // luma and divider seed
  ltsu_luma u_luma (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .base_luma (coef.base_luma),
    .ld_i      (cell_ld[0]),
    .ld_o      (front_ld),
    .v_o       (cell_v[0]),
    .item_o    (cell_it[0])
  );

  // division chain, msb of the weight first
  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
    ltsu_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .v_i       (cell_v[i]),
      .item_i    (cell_it[i]),
      .base_luma (coef.base_luma),
      .ld_i      (cell_ld[i+1]),
      .ld_o      (cell_ld[i]),
      .v_o       (cell_v[i+1]),
      .item_o    (cell_it[i+1])
    );
  end

  // products, rounding and output
  ltsu_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .v_i       (cell_v[DIV_CELLS]),
    .item_i    (cell_it[DIV_CELLS]),
    .coef      (coef),
    .ld_o      (cell_ld[DIV_CELLS]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: verif/tb_luma_weighted_tint_shift_unit.sv
// testbench for the luma weighted tint shift unit: drives pixels and register
// settings, predicts each shifted pixel and compares it with the block's output
// depends on ltsu_pkg and luma_weighted_tint_shift_unit
module tb_luma_weighted_tint_shift_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ltsu_pkg::*;

  localparam int unsigned REG_COUNT   = 6;
  localparam int unsigned PIPE_DEPTH  = 20;
  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned RAND_PIXELS = 85;
  localparam longint unsigned CYCLE_LIMIT = 250000;
  localparam longint WEIGHT_ONE = 65536;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  // holds the register shadow and the queue of predicted pixels
  class tint_scoreboard;
    cfg_t       regs;
    pix_out_t   pending_pixels[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      regs = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(int unsigned idx, logic [7:0] val);
      case (idx)
        REG_BASE_R: regs.base_r = val;
        REG_BASE_G: regs.base_g = val;
        REG_BASE_B: regs.base_b = val;
        REG_TINT_R: regs.tint_r = val;
        REG_TINT_G: regs.tint_g = val;
        REG_TINT_B: regs.tint_b = val;
        default: ;
      endcase
    endfunction

    function logic [7:0] reg_value(int unsigned idx);
      case (idx)
        REG_BASE_R: return regs.base_r;
        REG_BASE_G: return regs.base_g;
        REG_BASE_B: return regs.base_b;
        REG_TINT_R: return regs.tint_r;
        REG_TINT_G: return regs.tint_g;
        default:    return regs.tint_b;
      endcase
    endfunction

    function longint luma_sum(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      return 299 * longint'(r) + 587 * longint'(g) + 114 * longint'(b);
    endfunction

    // one channel moved by the weighted tint delta, rounded half up, clamped
    function logic [7:0] shifted_chan(logic [7:0] pv, logic [7:0] tint, logic [7:0] base,
                                      longint wt);
      longint d;
      longint num;
      longint v;
      d = longint'(tint) - longint'(base);
      num = longint'(pv) * 65536 + d * wt + 32768;
      // bias keeps the value positive so the shift floors
      v = ((num + 256 * 65536) >>> 16) - 256;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[7:0];
    endfunction

    function pix_out_t tinted_pixel(pix_in_t p);
      pix_out_t o;
      longint base_luma;
      longint wt;
      o.out_a = p.pixel_a;
      base_luma = luma_sum(regs.base_r, regs.base_g, regs.base_b);
      if (base_luma == 0) begin
        o.out_r = p.pixel_r;
        o.out_g = p.pixel_g;
        o.out_b = p.pixel_b;
      end else begin
        wt = (luma_sum(p.pixel_r, p.pixel_g, p.pixel_b) * 65536) / base_luma;
        if (wt > WEIGHT_ONE) wt = WEIGHT_ONE;
        o.out_r = shifted_chan(p.pixel_r, regs.tint_r, regs.base_r, wt);
        o.out_g = shifted_chan(p.pixel_g, regs.tint_g, regs.base_g, wt);
        o.out_b = shifted_chan(p.pixel_b, regs.tint_b, regs.base_b, wt);
      end
      return o;
    endfunction

    function void note_pixel(pix_in_t p);
      pending_pixels.push_back(tinted_pixel(p));
    endfunction

    function void check_pixel(pix_out_t got);
      pix_out_t want;
      if (pending_pixels.size() == 0) begin
        $error("unexpected output item %h", got);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      checked++;
      if (got.out_r !== want.out_r) begin
        $error("out_r expected %0d actual %0d", want.out_r, got.out_r);
        errors++;
      end
      if (got.out_g !== want.out_g) begin
        $error("out_g expected %0d actual %0d", want.out_g, got.out_g);
        errors++;
      end
      if (got.out_b !== want.out_b) begin
        $error("out_b expected %0d actual %0d", want.out_b, got.out_b);
        errors++;
      end
      if (got.out_a !== want.out_a) begin
        $error("out_a expected %0d actual %0d", want.out_a, got.out_a);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  pix_in_t               in_data;
  logic                  out_valid;
  logic                  out_stall;
  pix_out_t              out_data;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  tint_scoreboard sb = new();
  bit             hold_req;
  int unsigned    burst_left;
  int unsigned    settings_run;
  int unsigned    readback_errors;
  longint unsigned cycles;

  luma_weighted_tint_shift_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_luma_weighted_tint_shift_unit failed");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_pixel(out_data);
  end

  // receiver stall pattern, plus the long hold-off on request
  initial begin : receiver
    stall_mode_t mode;
    int unsigned seg;
    int unsigned i;
    out_stall = 1'b0;
    forever begin
      mode = stall_mode_t'($urandom_range(STALL_NONE, STALL_PERIODIC));
      seg = $urandom_range(5, 60);
      for (i = 0; i < seg; i++) begin
        @(negedge clk);
        if (hold_req) begin
          out_stall = 1'b1;
          repeat (HOLD_CYCLES - 1) @(negedge clk);
          hold_req = 1'b0;
        end else begin
          case (mode)
            STALL_NONE:   out_stall = 1'b0;
            STALL_LIGHT:  out_stall = ($urandom_range(0, 4) == 0);
            STALL_HEAVY:  out_stall = ($urandom_range(0, 9) < 6);
            default:      out_stall = ((i % 4) < 2);
          endcase
        end
      end
    end
  end

  // apb write; shadow follows only for existing registers
  task automatic cfg_write(input int unsigned idx, input logic [7:0] val);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = CFG_ADDR_W'(idx * 4);
    cfg_pwdata = CFG_DATA_W'(val);
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  // apb read of one register, compared with the shadow
  task automatic cfg_check(input int unsigned idx);
    logic [CFG_DATA_W-1:0] want;
    want = CFG_DATA_W'(sb.reg_value(idx));
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = CFG_ADDR_W'(idx * 4);
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want) begin
      $error("register %0d expected %0d actual %0d", idx, want, cfg_prdata);
      readback_errors++;
    end
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic set_colors(input cfg_t c);
    int unsigned i;
    cfg_write(REG_BASE_R, c.base_r);
    cfg_write(REG_BASE_G, c.base_g);
    cfg_write(REG_BASE_B, c.base_b);
    cfg_write(REG_TINT_R, c.tint_r);
    cfg_write(REG_TINT_G, c.tint_g);
    cfg_write(REG_TINT_B, c.tint_b);
    for (i = 0; i < REG_COUNT; i++) cfg_check(i);
    settings_run++;
  endtask

  // wait for every predicted pixel, then let the pipeline settle
  task automatic drain_pipe();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  // offer one pixel and hold it until taken; bursts end in random gaps
  task automatic send_pixel(input pix_in_t p);
    int unsigned gap;
    @(negedge clk);
    in_valid = 1'b1;
    in_data = p;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(p);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        in_data = $urandom;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  function automatic logic [7:0] near_base(logic [7:0] b, int unsigned k);
    int v;
    v = (int'(b) * int'(k)) / 16 + $urandom_range(0, 4) - 2;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic logic [7:0] edge_chan(logic [7:0] b);
    case ($urandom_range(0, 2))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return b;
    endcase
  endfunction

  // pixels scaled from the base by 0 to 20/16, edge channels, or random pixels
  function automatic pix_in_t gen_pixel();
    pix_in_t p;
    int unsigned pick;
    int unsigned k;
    p = $urandom;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      k = $urandom_range(0, 20);
      p.pixel_r = near_base(sb.regs.base_r, k);
      p.pixel_g = near_base(sb.regs.base_g, k);
      p.pixel_b = near_base(sb.regs.base_b, k);
    end else if (pick < 6) begin
      p.pixel_r = edge_chan(sb.regs.base_r);
      p.pixel_g = edge_chan(sb.regs.base_g);
      p.pixel_b = edge_chan(sb.regs.base_b);
    end
    return p;
  endfunction

  function automatic pix_in_t mk_pix(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                     logic [7:0] a);
    pix_in_t p;
    p.pixel_r = r;
    p.pixel_g = g;
    p.pixel_b = b;
    p.pixel_a = a;
    return p;
  endfunction

  function automatic cfg_t mk_cfg(logic [7:0] br, logic [7:0] bg, logic [7:0] bb,
                                  logic [7:0] tr, logic [7:0] tg, logic [7:0] tb);
    cfg_t c;
    c.base_r = br;
    c.base_g = bg;
    c.base_b = bb;
    c.tint_r = tr;
    c.tint_g = tg;
    c.tint_b = tb;
    return c;
  endfunction

  // main sequence
  initial begin : main
    cfg_t        plan[$];
    int unsigned ph;
    int unsigned n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    hold_req = 1'b0;
    burst_left = 1;
    settings_run = 0;
    readback_errors = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // reset values: zero base, colors pass through
    for (n = 0; n < REG_COUNT; n++) cfg_check(n);
    send_pixel(mk_pix(8'd0, 8'd0, 8'd0, 8'd0));
    send_pixel(mk_pix(8'd255, 8'd255, 8'd255, 8'd255));
    send_pixel(mk_pix(8'd17, 8'd200, 8'd99, 8'd128));
    drain_pipe();

    // mid gray base, tint with deltas of both signs
    set_colors(mk_cfg(8'd128, 8'd128, 8'd128, 8'd255, 8'd0, 8'd30));
    send_pixel(mk_pix(8'd0, 8'd0, 8'd0, 8'd255));
    send_pixel(mk_pix(8'd255, 8'd255, 8'd255, 8'd0));
    send_pixel(mk_pix(8'd128, 8'd128, 8'd128, 8'h5a));
    send_pixel(mk_pix(8'd64, 8'd64, 8'd64, 8'ha5));
    send_pixel(mk_pix(8'd255, 8'd0, 8'd0, 8'd1));
    send_pixel(mk_pix(8'd0, 8'd255, 8'd0, 8'd2));
    send_pixel(mk_pix(8'd0, 8'd0, 8'd255, 8'd4));
    send_pixel(mk_pix(8'd1, 8'd1, 8'd1, 8'd8));
    send_pixel(mk_pix(8'd127, 8'd128, 8'd128, 8'd16));
    send_pixel(mk_pix(8'd250, 8'd10, 8'd10, 8'd32));
    send_pixel(mk_pix(8'd10, 8'd10, 8'd250, 8'd64));
    send_pixel(mk_pix(8'd0, 8'd128, 8'd255, 8'd127));
    send_pixel(mk_pix(8'd200, 8'd200, 8'd100, 8'd254));
    drain_pipe();

    // zero base with a tint set: still a pass through
    set_colors(mk_cfg(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255));
    send_pixel(mk_pix(8'd3, 8'd128, 8'd250, 8'd77));
    send_pixel(mk_pix(8'd255, 8'd0, 8'd255, 8'd200));
    drain_pipe();
    // writes past the last register must not disturb anything
    cfg_write(REG_COUNT, 8'hff);
    cfg_write(REG_COUNT + 1, 8'h5a);
    for (n = 0; n < REG_COUNT; n++) cfg_check(n);

    // random phases over extreme and random settings
    plan.push_back(mk_cfg(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0));
    plan.push_back(mk_cfg(8'd1, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255));
    plan.push_back(mk_cfg(8'd0, 8'd0, 8'd1, 8'd0, 8'd255, 8'd0));
    plan.push_back(mk_cfg(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0));
    repeat (4) plan.push_back(cfg_t'({$urandom, $urandom}));
    for (ph = 0; ph < plan.size(); ph++) begin
      set_colors(plan[ph]);
      if (ph == 2) hold_req = 1'b1;
      for (n = 0; n < RAND_PIXELS; n++) send_pixel(gen_pixel());
      drain_pipe();
    end

    $display("checked %0d pixels over %0d register settings, covering zero base,",
             sb.checked, settings_run);
    $display("weight saturation, channel clamping and a long output hold-off");
    if (sb.errors == 0 && readback_errors == 0 && sb.pending_pixels.size() == 0) begin
      $display("tb_luma_weighted_tint_shift_unit passed");
    end else begin
      $display("tb_luma_weighted_tint_shift_unit failed");
    end
    $finish;
  end

endmodule
